### design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants and helpers for the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    // fixed field widths of the streaming payload
    localparam int IDX_W      = 13;
    localparam int ADDR_W     = 48;
    localparam int STATUS_W   = 2;
    localparam int REQ_W      = 2;
    localparam int WORD_OUT_W = 32;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    // index of the lowest set bit, zero when none
    function automatic logic [5:0] find_first_set(input logic [63:0] v);
        logic [5:0] res;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) begin
                res = 6'(i);
            end
        end
        return res;
    endfunction

endpackage

### design/bpa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bpa_bitmap_ram
// single write port, single read port bitmap store, registered read
// ----------------------------------------------------------------------------
module bpa_bitmap_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/bpa_index_split.sv
// ----------------------------------------------------------------------------
// bpa_index_split
// splits a page index into word and bit position, two-stage pipeline
// ----------------------------------------------------------------------------
module bpa_index_split #(
    parameter int WORD_BITS = 32,
    parameter int WA_W      = 8,
    parameter int BIT_W     = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [bpa_pkg::IDX_W-1:0] i_idx,
    output logic                     o_valid,
    output logic [WA_W-1:0]          o_word,
    output logic [BIT_W-1:0]         o_bit
);

    // reciprocal multiply, quotient estimate is exact or one low
    localparam int SH      = 20;
    localparam int RECIP_W = 21;
    localparam int RECIP   = (1 << SH) / WORD_BITS;
    localparam int PROD_W  = bpa_pkg::IDX_W + RECIP_W;
    localparam int Q_W     = PROD_W - SH;

    logic [PROD_W-1:0]         r_prod;
    logic [bpa_pkg::IDX_W-1:0] r_idx;
    logic                      r_v1;
    logic                      r_v2;
    logic [WA_W-1:0]           r_word;
    logic [BIT_W-1:0]          r_bit;

    logic [Q_W-1:0] w_q_est;
    logic [23:0]    w_rem;
    logic           w_fix;

    always_comb begin
        w_q_est = r_prod[PROD_W-1:SH];
        w_rem   = 24'(32'(r_idx) - 32'(w_q_est) * WORD_BITS);
        w_fix   = (32'(w_rem) >= WORD_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_prod <= PROD_W'(i_idx) * PROD_W'(RECIP);
        r_idx  <= i_idx;
        if (w_fix) begin
            r_word <= WA_W'(w_q_est + Q_W'(1));
            r_bit  <= BIT_W'(32'(w_rem) - WORD_BITS);
        end else begin
            r_word <= WA_W'(w_q_est);
            r_bit  <= BIT_W'(w_rem);
        end
    end

    assign o_valid = r_v2;
    assign o_word  = r_word;
    assign o_bit   = r_bit;

endmodule

### design/bitmap_page_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// first-fit page allocator over a free-page bitmap held in block memory
// ----------------------------------------------------------------------------
// One bit per page, 1 = free, WORD_BITS pages per memory word. Requests
// arrive on the slave stream (tuser = request kind, tdata = page index) and
// each produces exactly one result on the master stream. After reset the
// block runs a clearing pass that writes all ones to every bitmap word, one
// word per cycle, NUM_WORDS words in all (256 at the defaults); no request is
// taken during that pass, while pool_base writes are always taken. Items
// are handled one at a time. Free, mark-used and query go from transfer to
// result through the index split, a memory read, a read-modify-write and
// forming the address while loading the output register.
// Allocate scans bitmap words upward from a lowest-candidate-word pointer,
// each word visited with a memory read, then a test, after which the bit is
// encoded, the page number formed and the result loaded; the pointer means a
// scan normally touches one word. A full bitmap is remembered by the
// pointer, so a following allocate reports no free page without a scan. The
// next request is taken the cycle after a result is loaded. A finished
// result sits in the output register while the next request is already being
// taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
    parameter int NUM_PAGES  = 8192,
    parameter int WORD_BITS  = 32,
    parameter int PAGE_SHIFT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,    // [12:0] page number, [15:13] zero
    input  logic [1:0]  i_s_tuser,    // [1:0] req_type

    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,    // [12:0] result_page, [60:13] page_address,
                                      // [61] page_is_free, [93:62] bitmap_word,
                                      // [95:94] zero
    output logic [1:0]  o_m_tuser,    // [1:0] status

    // pool_base register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [47:0] i_cfg_data
);

    // ---- derived sizes ----
    localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int HINT_W    = $clog2(NUM_WORDS + 1);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int TAIL_BITS = NUM_PAGES - (NUM_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - TAIL_BITS);
    localparam logic [HINT_W-1:0] LAST_WORD = HINT_W'(NUM_WORDS - 1);
    localparam logic [HINT_W-1:0] ALL_FULL  = HINT_W'(NUM_WORDS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SPLIT,
        S_UPD_RD,
        S_UPD_MOD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ENC,
        S_PAGE,
        S_RESP
    } t_state;

    t_state r_state;

    // request and working registers
    logic [bpa_pkg::REQ_W-1:0]    r_req;
    logic [bpa_pkg::IDX_W-1:0]    r_idx;
    logic [HINT_W-1:0]            r_cnt;     // clear sweep and scan position
    logic [HINT_W-1:0]            r_hint;    // no free page below this word
    logic [WA_W-1:0]              r_word;
    logic [BIT_W-1:0]             r_bit;
    logic [WORD_BITS-1:0]         r_found;   // masked word hit by the scan
    logic [WORD_BITS-1:0]         r_bm;      // bitmap word after update
    logic [PAGE_W-1:0]            r_page;
    logic                         r_free;
    logic [bpa_pkg::STATUS_W-1:0] r_status;
    logic [bpa_pkg::ADDR_W-1:0]   r_pool;

    // output register
    logic                           r_m_valid;
    logic [bpa_pkg::STATUS_W-1:0]   r_m_status;
    logic [bpa_pkg::IDX_W-1:0]      r_m_page;
    logic [bpa_pkg::ADDR_W-1:0]     r_m_addr;
    logic                           r_m_free;
    logic [bpa_pkg::WORD_OUT_W-1:0] r_m_word;

    // memory port
    logic                 w_we;
    logic [WA_W-1:0]      w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [WA_W-1:0]      w_raddr;
    logic [WORD_BITS-1:0] w_rdata;

    // index split
    logic                 w_split_start;
    logic                 w_split_valid;
    logic [WA_W-1:0]      w_split_word;
    logic [BIT_W-1:0]     w_split_bit;

    logic                 w_s_xfer;
    logic                 w_in_range;
    logic [WORD_BITS-1:0] w_bit_mask;
    logic [WORD_BITS-1:0] w_upd_word;
    logic [WORD_BITS-1:0] w_scan_masked;
    logic [WORD_BITS-1:0] w_alloc_word;
    logic                 w_out_free;
    logic [bpa_pkg::ADDR_W-1:0] w_page_off;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_in_range = (32'(i_s_tdata[bpa_pkg::IDX_W-1:0]) < NUM_PAGES);
    assign w_split_start = w_s_xfer && (i_s_tuser != bpa_pkg::REQ_ALLOC) && w_in_range;
    assign w_out_free = !r_m_valid || i_m_tready;

    // read-modify-write of a single page bit
    always_comb begin
        w_bit_mask = WORD_BITS'(1) << r_bit;
        case (r_req)
            bpa_pkg::REQ_FREE: w_upd_word = w_rdata | w_bit_mask;
            bpa_pkg::REQ_MARK: w_upd_word = w_rdata & ~w_bit_mask;
            default:           w_upd_word = w_rdata;
        endcase
    end

    // scan test: tail word hides bits past the last page
    // lowest set bit of the raw word equals that of the masked word when non-zero
    assign w_scan_masked = w_rdata & ((r_cnt == LAST_WORD) ? TAIL_MASK : {WORD_BITS{1'b1}});
    assign w_alloc_word  = w_rdata & (w_rdata - WORD_BITS'(1));

    assign w_page_off = bpa_pkg::ADDR_W'(64'(r_page) << PAGE_SHIFT);

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[WA_W-1:0];
        w_wdata = {WORD_BITS{1'b1}};
        w_raddr = r_cnt[WA_W-1:0];
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_UPD_RD: begin
                w_raddr = r_word;
            end
            S_UPD_MOD: begin
                w_we    = (r_req == bpa_pkg::REQ_FREE) || (r_req == bpa_pkg::REQ_MARK);
                w_waddr = r_word;
                w_wdata = w_upd_word;
            end
            S_SCAN_CHK: begin
                w_we    = (w_scan_masked != '0);
                w_wdata = w_alloc_word;
            end
            default: begin
            end
        endcase
    end

    bpa_bitmap_ram #(
        .DEPTH  (NUM_WORDS),
        .DATA_W (WORD_BITS),
        .ADDR_W (WA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bpa_index_split #(
        .WORD_BITS (WORD_BITS),
        .WA_W      (WA_W),
        .BIT_W     (BIT_W)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_split_start),
        .i_idx   (i_s_tdata[bpa_pkg::IDX_W-1:0]),
        .o_valid (w_split_valid),
        .o_word  (w_split_word),
        .o_bit   (w_split_bit)
    );

    // pool base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= '0;
        end else if (i_cfg_valid) begin
            r_pool <= i_cfg_data;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_hint    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // result taken; a new one loaded in S_RESP refills the register
            if (r_m_valid && i_m_tready && (r_state != S_RESP)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt == LAST_WORD) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + HINT_W'(1);
                    end
                end
                S_IDLE: begin
                    if (w_s_xfer) begin
                        r_req    <= i_s_tuser;
                        r_idx    <= i_s_tdata[bpa_pkg::IDX_W-1:0];
                        r_page   <= PAGE_W'(i_s_tdata[bpa_pkg::IDX_W-1:0]);
                        r_free   <= 1'b0;
                        r_bm     <= '0;
                        if (i_s_tuser == bpa_pkg::REQ_ALLOC) begin
                            if (r_hint == ALL_FULL) begin
                                r_status <= bpa_pkg::ST_NO_FREE;
                                r_state  <= S_RESP;
                            end else begin
                                r_status <= bpa_pkg::ST_OK;
                                r_cnt    <= r_hint;
                                r_state  <= S_SCAN_RD;
                            end
                        end else if (!w_in_range) begin
                            r_status <= bpa_pkg::ST_RANGE;
                            r_state  <= S_RESP;
                        end else begin
                            r_status <= bpa_pkg::ST_OK;
                            r_state  <= S_SPLIT;
                        end
                    end
                end
                S_SPLIT: begin
                    if (w_split_valid) begin
                        r_word  <= w_split_word;
                        r_bit   <= w_split_bit;
                        r_state <= S_UPD_RD;
                    end
                end
                S_UPD_RD: begin
                    r_state <= S_UPD_MOD;
                end
                S_UPD_MOD: begin
                    r_bm    <= w_upd_word;
                    r_free  <= w_upd_word[r_bit];
                    if ((r_req == bpa_pkg::REQ_FREE) && (HINT_W'(r_word) < r_hint)) begin
                        r_hint <= HINT_W'(r_word);
                    end
                    r_state <= S_RESP;
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (w_scan_masked != '0) begin
                        r_found <= w_scan_masked;
                        r_bm    <= w_alloc_word;
                        r_hint  <= r_cnt;
                        r_state <= S_ENC;
                    end else if (r_cnt == LAST_WORD) begin
                        r_hint   <= ALL_FULL;
                        r_status <= bpa_pkg::ST_NO_FREE;
                        r_state  <= S_RESP;
                    end else begin
                        r_cnt   <= r_cnt + HINT_W'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_ENC: begin
                    r_bit   <= BIT_W'(bpa_pkg::find_first_set(64'(r_found)));
                    r_state <= S_PAGE;
                end
                S_PAGE: begin
                    r_page  <= PAGE_W'(32'(r_cnt) * WORD_BITS + 32'(r_bit));
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // wait for the output register, then publish the result
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_status;
                        r_m_free   <= r_free;
                        r_m_word   <= bpa_pkg::WORD_OUT_W'(r_bm);
                        if (r_status == bpa_pkg::ST_OK) begin
                            r_m_page <= bpa_pkg::IDX_W'(r_page);
                            r_m_addr <= r_pool + w_page_off;
                        end else begin
                            r_m_page <= (r_status == bpa_pkg::ST_RANGE) ? r_idx : '0;
                            r_m_addr <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = {2'b00, r_m_word, r_m_free, r_m_addr, r_m_page};

endmodule

### tb/tb_bitmap_page_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_core
// self-checking bench for the first-fit bitmap page allocator
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and every transfer on the master stream
// is checked field by field against a local model of the free-page bitmap
// and the pool base. A short table of hand-picked requests comes first, part
// of it with the pool base at all ones so that addresses wrap, then three
// random phases mix allocate, free, mark-used and query requests under
// different amounts of idling on both streams, with one long result stall
// that backs the block up.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator_core;

    localparam int NUM_PAGES  = 8192;
    localparam int WORD_BITS  = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int NUM_WORDS  = NUM_PAGES / WORD_BITS;

    // quiet cycles before a pool_base write and at the end of the run
    localparam int QUIET_CYCLES = 16;
    // long result stall, in cycles, used once in the first random phase
    localparam int HOLD_CYCLES  = 400;
    // hard stop
    localparam longint RUN_LIMIT = 64'd400_000_000;

    // one result as it travels on the master stream
    typedef struct packed {
        logic [bpa_pkg::STATUS_W-1:0]   status;
        logic [bpa_pkg::IDX_W-1:0]      page;
        logic [bpa_pkg::ADDR_W-1:0]     addr;
        logic                           is_free;
        logic [bpa_pkg::WORD_OUT_W-1:0] word;
    } t_page_result;

    // one row of the hand-picked stimulus table
    typedef struct packed {
        logic [bpa_pkg::REQ_W-1:0] req;
        logic [bpa_pkg::IDX_W-1:0] page;
        logic                      typed;     // 1: the result below is the expected one
        t_page_result              res;
    } t_request_row;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;

    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [15:0] req_data  = '0;     // [12:0] page number, [15:13] zero
    logic [1:0]  req_user  = '0;     // [1:0] req_type

    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [95:0] res_data;           // [12:0] result_page, [60:13] page_address,
                                     // [61] page_is_free, [93:62] bitmap_word
    logic [1:0]  res_user;           // [1:0] status

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [47:0] cfg_data  = '0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bitmap_page_allocator_core #(
        .NUM_PAGES  (NUM_PAGES),
        .WORD_BITS  (WORD_BITS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (req_valid),
        .o_s_tready (req_ready),
        .i_s_tdata  (req_data),
        .i_s_tuser  (req_user),
        .o_m_tvalid (res_valid),
        .i_m_tready (res_ready),
        .o_m_tdata  (res_data),
        .o_m_tuser  (res_user),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // model state, expected results and bookkeeping
    // ------------------------------------------------------------------------
    logic [WORD_BITS-1:0]       free_map [NUM_WORDS];   // 1 = page free
    logic [bpa_pkg::ADDR_W-1:0] pool_base_model;
    t_page_result               expected_page_results [$];

    int  mismatches      = 0;
    int  results_checked = 0;
    int  items_sent      = 0;
    int  no_free_seen    = 0;
    int  cfg_writes      = 0;

    // idling, in percent; set per phase by the stimulus process
    int  tx_idle_pct     = 0;
    int  rx_idle_pct     = 0;
    int  phase_id        = 0;
    logic hold_active    = 1'b0;

    // ------------------------------------------------------------------------
    // hand-picked requests
    // rows below DIR_SPLIT run on a fresh bitmap with pool_base zero, the rest
    // continue from there with pool_base all ones, so addresses wrap
    // ------------------------------------------------------------------------
    localparam int DIR_ROWS  = 25;
    localparam int DIR_SPLIT = 15;

    t_request_row dir_rows [DIR_ROWS] = '{
        // fresh bitmap, reset values
        '{bpa_pkg::REQ_QUERY, 13'd0,    1'b1,
          '{bpa_pkg::ST_OK, 13'd0,    48'h0,        1'b1, 32'hFFFF_FFFF}},
        '{bpa_pkg::REQ_ALLOC, 13'd8191, 1'b1,
          '{bpa_pkg::ST_OK, 13'd0,    48'h0,        1'b0, 32'hFFFF_FFFE}},
        '{bpa_pkg::REQ_ALLOC, 13'd0,    1'b1,
          '{bpa_pkg::ST_OK, 13'd1,    48'h1000,     1'b0, 32'hFFFF_FFFC}},
        // top page, marked twice and freed
        '{bpa_pkg::REQ_QUERY, 13'd8191, 1'b1,
          '{bpa_pkg::ST_OK, 13'd8191, 48'h1FF_F000, 1'b1, 32'hFFFF_FFFF}},
        '{bpa_pkg::REQ_MARK,  13'd8191, 1'b1,
          '{bpa_pkg::ST_OK, 13'd8191, 48'h1FF_F000, 1'b0, 32'h7FFF_FFFF}},
        '{bpa_pkg::REQ_MARK,  13'd8191, 1'b1,
          '{bpa_pkg::ST_OK, 13'd8191, 48'h1FF_F000, 1'b0, 32'h7FFF_FFFF}},
        '{bpa_pkg::REQ_FREE,  13'd8191, 1'b1,
          '{bpa_pkg::ST_OK, 13'd8191, 48'h1FF_F000, 1'b1, 32'hFFFF_FFFF}},
        // freeing a page that is already free
        '{bpa_pkg::REQ_FREE,  13'd5,    1'b1,
          '{bpa_pkg::ST_OK, 13'd5,    48'h5000,     1'b1, 32'hFFFF_FFFC}},
        // freeing page zero puts the lowest page back in front
        '{bpa_pkg::REQ_FREE,  13'd0,    1'b1,
          '{bpa_pkg::ST_OK, 13'd0,    48'h0,        1'b1, 32'hFFFF_FFFD}},
        '{bpa_pkg::REQ_ALLOC, 13'd4095, 1'b1,
          '{bpa_pkg::ST_OK, 13'd0,    48'h0,        1'b0, 32'hFFFF_FFFC}},
        '{bpa_pkg::REQ_MARK,  13'd2,    1'b0, '0},
        '{bpa_pkg::REQ_MARK,  13'd31,   1'b0, '0},
        '{bpa_pkg::REQ_ALLOC, 13'd1234, 1'b0, '0},
        '{bpa_pkg::REQ_QUERY, 13'h1555, 1'b0, '0},
        '{bpa_pkg::REQ_FREE,  13'h0AAA, 1'b0, '0},
        // pool_base all ones, pages 0 to 3 and 31 in use
        '{bpa_pkg::REQ_QUERY, 13'd100,  1'b1,
          '{bpa_pkg::ST_OK, 13'd100,  48'h6_3FFF,   1'b1, 32'hFFFF_FFFF}},
        '{bpa_pkg::REQ_ALLOC, 13'd8191, 1'b1,
          '{bpa_pkg::ST_OK, 13'd4,    48'h3FFF,     1'b0, 32'h7FFF_FFE0}},
        '{bpa_pkg::REQ_MARK,  13'd8191, 1'b1,
          '{bpa_pkg::ST_OK, 13'd8191, 48'h1FF_EFFF, 1'b0, 32'h7FFF_FFFF}},
        '{bpa_pkg::REQ_FREE,  13'd8191, 1'b1,
          '{bpa_pkg::ST_OK, 13'd8191, 48'h1FF_EFFF, 1'b1, 32'hFFFF_FFFF}},
        '{bpa_pkg::REQ_FREE,  13'd0,    1'b1,
          '{bpa_pkg::ST_OK, 13'd0,    48'hFFFF_FFFF_FFFF, 1'b1, 32'h7FFF_FFE1}},
        '{bpa_pkg::REQ_ALLOC, 13'd0,    1'b1,
          '{bpa_pkg::ST_OK, 13'd0,    48'hFFFF_FFFF_FFFF, 1'b0, 32'h7FFF_FFE0}},
        '{bpa_pkg::REQ_FREE,  13'd31,   1'b1,
          '{bpa_pkg::ST_OK, 13'd31,   48'h1_EFFF,   1'b1, 32'hFFFF_FFE0}},
        '{bpa_pkg::REQ_QUERY, 13'd4000, 1'b1,
          '{bpa_pkg::ST_OK, 13'd4000, 48'hF9_FFFF,  1'b1, 32'hFFFF_FFFF}},
        '{bpa_pkg::REQ_MARK,  13'd4000, 1'b1,
          '{bpa_pkg::ST_OK, 13'd4000, 48'hF9_FFFF,  1'b0, 32'hFFFF_FFFE}},
        '{bpa_pkg::REQ_FREE,  13'd4000, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // model of one request: updates the bitmap and returns the result
    // ------------------------------------------------------------------------
    function automatic t_page_result predict_page_result(
        input logic [bpa_pkg::REQ_W-1:0] req,
        input logic [bpa_pkg::IDX_W-1:0] page);
        t_page_result              r;
        int                        w;
        int                        b;
        logic [bpa_pkg::IDX_W-1:0] pg;
        r = '0;
        if (req == bpa_pkg::REQ_ALLOC) begin
            // first fit: lowest word with a free bit, then its lowest bit
            w = 0;
            while (w < NUM_WORDS && free_map[w] == '0) w++;
            if (w == NUM_WORDS) begin
                r.status = bpa_pkg::ST_NO_FREE;
                return r;
            end
            b = 0;
            while (!free_map[w][b]) b++;
            free_map[w][b] = 1'b0;
            pg = bpa_pkg::IDX_W'(w * WORD_BITS + b);
        end else begin
            if (int'(page) >= NUM_PAGES) begin
                r.status = bpa_pkg::ST_RANGE;
                r.page   = page;
                return r;
            end
            pg = page;
            w  = int'(page) / WORD_BITS;
            b  = int'(page) % WORD_BITS;
            if (req == bpa_pkg::REQ_FREE) begin
                free_map[w][b] = 1'b1;
            end else if (req == bpa_pkg::REQ_MARK) begin
                free_map[w][b] = 1'b0;
            end
        end
        r.status  = bpa_pkg::ST_OK;
        r.page    = pg;
        // wraps at 48 bits
        r.addr    = pool_base_model + (bpa_pkg::ADDR_W'(pg) << PAGE_SHIFT);
        r.is_free = free_map[w][b];
        r.word    = free_map[w];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // request side: one transfer per call, entered and left at a rising edge
    // valid stays high from one request to the next unless an idle gap falls
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [bpa_pkg::REQ_W-1:0] req,
                                input logic [bpa_pkg::IDX_W-1:0] page,
                                input logic typed, input t_page_result typed_res);
        int           gap;
        t_page_result r;
        gap = 0;
        while (tx_idle_pct > 0 && gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= {{(16 - bpa_pkg::IDX_W){1'b0}}, page};
        req_user  <= req;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        // transfer took place at this edge
        r = predict_page_result(req, page);
        expected_page_results.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    // stop offering, let every result come back, then a few quiet cycles
    task automatic finish_burst();
        req_valid <= 1'b0;
        while (expected_page_results.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_pool_base(input logic [bpa_pkg::ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid       <= 1'b0;
        pool_base_model  = value;
        cfg_writes++;
    endtask

    // random mix; weights in percent, query takes what is left
    // most indices fall in a 256-page window that moves every 64 requests
    task automatic run_random_phase(input int n_items, input int w_alloc,
                                    input int w_free, input int w_mark);
        int                        k;
        int                        roll;
        logic [bpa_pkg::REQ_W-1:0] req;
        logic [bpa_pkg::IDX_W-1:0] page;
        logic [bpa_pkg::IDX_W-1:0] window;
        window = '0;
        for (k = 0; k < n_items; k++) begin
            if (k % 64 == 0) begin
                window = bpa_pkg::IDX_W'($urandom_range(0, NUM_PAGES / 256 - 1) * 256);
            end
            roll = $urandom_range(0, 99);
            if (roll < w_alloc) begin
                req = bpa_pkg::REQ_ALLOC;
            end else if (roll < w_alloc + w_free) begin
                req = bpa_pkg::REQ_FREE;
            end else if (roll < w_alloc + w_free + w_mark) begin
                req = bpa_pkg::REQ_MARK;
            end else begin
                req = bpa_pkg::REQ_QUERY;
            end
            if ($urandom_range(0, 99) < 60) begin
                page = window + bpa_pkg::IDX_W'($urandom_range(0, 255));
            end else begin
                page = bpa_pkg::IDX_W'($urandom_range(0, NUM_PAGES - 1));
            end
            send_request(req, page, 1'b0, '0);
        end
        finish_burst();
    endtask

    // ------------------------------------------------------------------------
    // result side: check each transfer, then pick ready for the next cycle
    // ------------------------------------------------------------------------
    initial begin
        t_page_result want;
        forever begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready) begin
                if (expected_page_results.size() == 0) begin
                    report_mismatch("result with nothing expected", res_data[63:0], '0);
                end else begin
                    want = expected_page_results.pop_front();
                    if (res_user != want.status) begin
                        report_mismatch("status", res_user, want.status);
                    end
                    if (res_data[bpa_pkg::IDX_W-1:0] != want.page) begin
                        report_mismatch("result_page", res_data[bpa_pkg::IDX_W-1:0],
                                        want.page);
                    end
                    if (res_data[bpa_pkg::IDX_W +: bpa_pkg::ADDR_W] != want.addr) begin
                        report_mismatch("page_address",
                                        res_data[bpa_pkg::IDX_W +: bpa_pkg::ADDR_W],
                                        want.addr);
                    end
                    if (res_data[bpa_pkg::IDX_W + bpa_pkg::ADDR_W] != want.is_free) begin
                        report_mismatch("page_is_free",
                                        res_data[bpa_pkg::IDX_W + bpa_pkg::ADDR_W],
                                        want.is_free);
                    end
                    if (res_data[bpa_pkg::IDX_W + bpa_pkg::ADDR_W + 1 +: bpa_pkg::WORD_OUT_W]
                        != want.word) begin
                        report_mismatch("bitmap_word",
                            res_data[bpa_pkg::IDX_W + bpa_pkg::ADDR_W + 1 +:
                                     bpa_pkg::WORD_OUT_W],
                            want.word);
                    end
                    if (want.status == bpa_pkg::ST_NO_FREE) begin
                        no_free_seen++;
                    end
                end
                results_checked++;
            end
            if (hold_active) begin
                res_ready <= 1'b0;
            end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // long result stall early in the first random phase, so the output
    // register and the request stage both fill and the input backs up
    initial begin
        wait (phase_id == 3);
        repeat (40) @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int i;

        foreach (free_map[w]) free_map[w] = '1;
        pool_base_model = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // written while the block still clears its bitmap
        write_pool_base('0);

        // phase 1: table rows on a fresh bitmap
        phase_id    = 1;
        tx_idle_pct = 12;
        rx_idle_pct = 60;
        for (i = 0; i < DIR_SPLIT; i++) begin
            send_request(dir_rows[i].req, dir_rows[i].page, dir_rows[i].typed,
                         dir_rows[i].res);
        end
        finish_burst();

        // phase 2: top pool base, remaining table rows with wrapping addresses
        phase_id    = 2;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_pool_base('1);
        for (i = DIR_SPLIT; i < DIR_ROWS; i++) begin
            send_request(dir_rows[i].req, dir_rows[i].page, dir_rows[i].typed,
                         dir_rows[i].res);
        end
        finish_burst();

        // phase 3: free-heavy mix, slow receiver
        phase_id    = 3;
        tx_idle_pct = 12;
        rx_idle_pct = 60;
        write_pool_base({16'($urandom), 32'($urandom)});
        run_random_phase(520, 25, 45, 10);

        // phase 4: balanced mix, slow sender
        phase_id    = 4;
        tx_idle_pct = 60;
        rx_idle_pct = 12;
        write_pool_base(48'hFFFF_FFFF_F000);
        run_random_phase(520, 35, 30, 15);

        // phase 5: allocate-heavy mix, no idling on either side
        phase_id    = 5;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_pool_base({16'($urandom), 32'($urandom)});
        run_random_phase(520, 45, 25, 10);

        // anything arriving now would be unexpected
        repeat (QUIET_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d checked results, %0d of them no-free",
                 items_sent, results_checked, no_free_seen);
        $display("pool_base written %0d times, wrapping addresses, one long result stall",
                 cfg_writes);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
